### rtl/tpp_pkg.sv
`default_nettype none

package tpp_pkg;

  localparam int LONG_FRAME_BYTES  = 16;
  localparam int SHORT_FRAME_BYTES = 12;
  localparam int MAX_EMIT          = 16;

  localparam int LONG_EMIT  = (LONG_FRAME_BYTES > MAX_EMIT) ? MAX_EMIT : LONG_FRAME_BYTES;
  localparam int SHORT_EMIT = (SHORT_FRAME_BYTES > MAX_EMIT) ? MAX_EMIT : SHORT_FRAME_BYTES;

  localparam logic [3:0] LONG_LAST  = 4'(LONG_EMIT - 1);
  localparam logic [3:0] SHORT_LAST = 4'(SHORT_EMIT - 1);

  localparam logic [7:0]  HDR_TAG    = 8'h04;
  localparam logic [15:0] SAT_COUNT  = 16'h7fff;
  localparam logic [15:0] SAT_U16    = 16'hffff;
  localparam logic [15:0] SAT_S16_HI = 16'h7fff;
  localparam logic [15:0] SAT_S16_LO = 16'h8000;
  localparam logic [15:0] MARKER_RST = 16'h8000;

  // Quotient bits resolved by the average divider after its range check.
  localparam int DIV_STEPS = 15;

  // Command codes.
  localparam logic [1:0] CMD_SENSOR_LONG   = 2'd0;
  localparam logic [1:0] CMD_COUNTER_LONG  = 2'd1;
  localparam logic [1:0] CMD_SENSOR_SHORT  = 2'd2;
  localparam logic [1:0] CMD_COUNTER_SHORT = 2'd3;

  // Register indexes.
  localparam logic [1:0] REG_DEVICE_ID        = 2'd0;
  localparam logic [1:0] REG_FIRMWARE_VERSION = 2'd1;
  localparam logic [1:0] REG_MISSING_MARKER   = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] channel_reading;
    logic [31:0]        battery_millivolts;
    logic [7:0]         range_code;
    logic signed [31:0] temperature_tenths;
    logic [31:0]        peak_people;
    logic [31:0]        people_sum;
    logic [31:0]        scan_total;
    logic [31:0]        motion_events;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] byte_position;
    logic       final_byte;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  device_id;
    logic [7:0]  firmware_version;
    logic [15:0] missing_marker;
  } cfg_t;

  // One packed frame waiting for the serializer.
  typedef struct packed {
    logic             is_long;
    logic [15:0][7:0] bytes;
  } frame_t;

endpackage

`default_nettype wire

### rtl/telemetry_payload_packer.sv
// Telemetry payload packer.
// Input channel (in_valid / in_ready / in_item): one sensor or people-counter
// report per item; command picks long (16-byte, with header) or short
// (12-byte) layout. Output channel (out_valid / out_ready / out_item): one
// payload byte per item, lowest offset first, final_byte set on the last one.
// Configuration: cfg_write with cfg_index / cfg_data writes device id,
// firmware version or the missing marker; write only while the block idles.
// Path: a report is registered in the front's hold register, pushed into the
// frame queue, loaded into the serializer's current frame and shown from the
// output register. A counter report with scans first runs the average divider
// (a range check, then 15 quotient bits, or the range check alone when it
// clamps the average), and the front takes no new report until it is done.
// The serializer sends the bytes of consecutive frames back to back while the
// receiver is ready.
// A two-entry frame queue parts front and back, so the front keeps taking
// reports while the receiver stalls until both entries fill and a third
// frame waits in the front; a stalled output byte holds in the output register.
// Reset clears the pipeline and queue and sets the registers to device id 0,
// firmware version 0 and missing marker 0x8000.
`default_nettype none

module telemetry_payload_packer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tpp_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tpp_pkg::out_item_t      out_item,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  tpp_pkg::cfg_t   cfg;
  logic            push_valid;
  logic            push_ready;
  tpp_pkg::frame_t push_frame;
  logic            q_valid;
  logic            q_pop;
  tpp_pkg::frame_t q_frame;

  // Configuration registers; an unused index drops the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_id        <= '0;
      cfg.firmware_version <= '0;
      cfg.missing_marker   <= tpp_pkg::MARKER_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tpp_pkg::REG_DEVICE_ID:        cfg.device_id        <= cfg_data[7:0];
        tpp_pkg::REG_FIRMWARE_VERSION: cfg.firmware_version <= cfg_data[7:0];
        tpp_pkg::REG_MISSING_MARKER:   cfg.missing_marker   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept, average and build frames.
  tpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame)
  );

  // Hold finished frames between the two sides.
  tpp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_frame  (q_frame)
  );

  // Emit one byte per cycle while the receiver is ready.
  tpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_frame   (q_frame),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### rtl/tpp_div.sv
`default_nettype none

// Restoring divider for the counter average: range check, then one
// quotient bit per cycle. Result is clamped to 32767.
module tpp_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [35:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [15:0]      result
);

  logic        busy;
  logic        chk;
  logic [35:0] rem;
  logic [45:0] dsr;
  logic [14:0] q;
  logic [3:0]  cnt;
  logic        fits;

  assign fits = ({10'b0, rem} >= dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        chk  <= 1'b1;
        rem  <= dividend;
        dsr  <= {divisor, 14'b0};
        cnt  <= '0;
        q    <= '0;
      end else if (busy) begin
        if (chk) begin
          chk <= 1'b0;
          // quotient of 32768 or more saturates
          if ({11'b0, rem} >= {dsr, 1'b0}) begin
            busy   <= 1'b0;
            done   <= 1'b1;
            result <= tpp_pkg::SAT_COUNT;
          end
        end else begin
          if (fits) begin
            rem <= rem - dsr[35:0];
          end
          q   <= {q[13:0], fits};
          dsr <= dsr >> 1;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(tpp_pkg::DIV_STEPS - 1)) begin
            busy   <= 1'b0;
            done   <= 1'b1;
            result <= {1'b0, q[13:0], fits};
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tpp_front.sv
`default_nettype none

// Front end: take an item, run the average divider when needed, build the
// frame bytes and hand them to the queue.
module tpp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tpp_pkg::in_item_t in_item,
  input  wire tpp_pkg::cfg_t     cfg,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output tpp_pkg::frame_t        push_frame
);

  typedef enum logic [2:0] {
    FR_EMPTY = 3'b001,
    FR_DIV   = 3'b010,
    FR_DONE  = 3'b100
  } fr_state_t;

  fr_state_t         state, state_next;
  tpp_pkg::in_item_t hold;
  logic [15:0]       avg;
  logic              accept;
  logic              needs_div;
  logic [35:0]       dividend;
  logic              div_done;
  logic [15:0]       div_result;

  function automatic logic [15:0] sat_s16(input logic [31:0] v);
    if (!v[31] && (v[30:15] != 16'h0000)) return tpp_pkg::SAT_S16_HI;
    if (v[31] && (v[30:15] != 16'hffff)) return tpp_pkg::SAT_S16_LO;
    return v[15:0];
  endfunction

  function automatic logic [15:0] clamp_count(input logic [31:0] v);
    return (v[31:15] != '0) ? tpp_pkg::SAT_COUNT : {1'b0, v[14:0]};
  endfunction

  function automatic logic [15:0] clamp_u16(input logic [31:0] v);
    return (v[31:16] != '0) ? tpp_pkg::SAT_U16 : v[15:0];
  endfunction

  assign in_ready   = (state == FR_EMPTY) || ((state == FR_DONE) && push_ready);
  assign accept     = in_valid && in_ready;
  assign needs_div  = in_item.command[0] && (in_item.scan_total != '0);
  assign push_valid = (state == FR_DONE);

  // 10 * sum + scans / 2
  assign dividend = ({4'b0, in_item.people_sum} << 3) + ({4'b0, in_item.people_sum} << 1)
                  + {5'b0, in_item.scan_total[31:1]};

  tpp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && needs_div),
    .dividend (dividend),
    .divisor  (in_item.scan_total),
    .done     (div_done),
    .result   (div_result)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      FR_EMPTY: begin
        if (accept) state_next = needs_div ? FR_DIV : FR_DONE;
      end
      FR_DIV: begin
        if (div_done) state_next = FR_DONE;
      end
      FR_DONE: begin
        if (accept) state_next = needs_div ? FR_DIV : FR_DONE;
        else if (push_ready) state_next = FR_EMPTY;
      end
      default: state_next = FR_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) hold <= in_item;
    if (div_done) avg <= div_result;
  end

  // Frame assembly.
  always_comb begin
    logic              is_long;
    logic              counter;
    logic              measured;
    logic [15:0]       marker;
    logic [15:0]       batt;
    logic [15:0]       temp16;
    logic [3:0][15:0]  fld;

    is_long  = !hold.command[1];
    counter  = hold.command[0];
    measured = (hold.scan_total != '0);
    marker   = cfg.missing_marker;
    batt     = clamp_u16(hold.battery_millivolts);
    temp16   = sat_s16(hold.temperature_tenths);

    if (counter) begin
      fld[0] = measured ? clamp_count(hold.peak_people) : marker;
      fld[1] = measured ? avg : marker;
      fld[2] = clamp_count(hold.motion_events);
      fld[3] = clamp_count(hold.scan_total);
    end else begin
      fld[0] = sat_s16(hold.channel_reading);
      fld[1] = marker;
      fld[2] = marker;
      fld[3] = marker;
    end

    push_frame.is_long = is_long;
    push_frame.bytes   = '0;
    if (is_long) begin
      push_frame.bytes[0] = tpp_pkg::HDR_TAG;
      push_frame.bytes[1] = cfg.device_id;
      push_frame.bytes[2] = cfg.firmware_version;
      for (int j = 0; j < 4; j++) begin
        push_frame.bytes[3 + 2 * j] = fld[j][7:0];
        push_frame.bytes[4 + 2 * j] = fld[j][15:8];
      end
      push_frame.bytes[11] = batt[7:0];
      push_frame.bytes[12] = batt[15:8];
      if (!counter) push_frame.bytes[15] = hold.range_code;
    end else begin
      for (int j = 0; j < 4; j++) begin
        push_frame.bytes[2 * j]     = fld[j][7:0];
        push_frame.bytes[2 * j + 1] = fld[j][15:8];
      end
      push_frame.bytes[8]  = temp16[7:0];
      push_frame.bytes[9]  = temp16[15:8];
      push_frame.bytes[10] = batt[7:0];
      push_frame.bytes[11] = batt[15:8];
    end
  end

endmodule

`default_nettype wire

### rtl/tpp_queue.sv
`default_nettype none

// Two-entry frame queue between front and back.
module tpp_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire tpp_pkg::frame_t push_frame,
  output logic                 pop_valid,
  input  wire logic            pop,
  output tpp_pkg::frame_t      pop_frame
);

  tpp_pkg::frame_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_frame  = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_frame;
  end

endmodule

`default_nettype wire

### rtl/tpp_back.sv
`default_nettype none

// Back end: walk the current frame one byte a cycle into the output register while it is not stalled.
module tpp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire tpp_pkg::frame_t q_frame,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tpp_pkg::out_item_t   out_item
);

  tpp_pkg::frame_t cur;
  logic            cur_valid;
  logic [3:0]      pos;
  logic            cur_final;
  logic            adv;

  assign cur_final = (pos == (cur.is_long ? tpp_pkg::LONG_LAST : tpp_pkg::SHORT_LAST));
  assign adv       = cur_valid && (!out_valid || out_ready);
  assign q_pop     = q_valid && (!cur_valid || (adv && cur_final));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        pos       <= '0;
      end else if (adv && cur_final) begin
        cur_valid <= 1'b0;
      end else if (adv) begin
        pos <= pos + 4'd1;
      end
      if (!out_valid || out_ready) out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_frame;
    if (adv) begin
      out_item.payload_byte  <= cur.bytes[pos];
      out_item.byte_position <= pos;
      out_item.final_byte    <= cur_final;
    end
  end

endmodule

`default_nettype wire

### rtl/tpp_checker.sv
`default_nettype none

module tpp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire tpp_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire tpp_pkg::out_item_t out_item
);

  logic [3:0] exp_pos;

  // Track the offset the next output byte must carry.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_pos <= '0;
    end else if (out_valid && out_ready) begin
      exp_pos <= out_item.final_byte ? 4'd0 : out_item.byte_position + 4'd1;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input item changed while waiting");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.byte_position == exp_pos)
    else $error("byte offset out of sequence");

  a_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.final_byte |->
      (out_item.byte_position == tpp_pkg::LONG_LAST) ||
      (out_item.byte_position == tpp_pkg::SHORT_LAST))
    else $error("final byte at wrong offset");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind telemetry_payload_packer tpp_checker u_tpp_checker (.*);

`default_nettype wire

### verif/tb_telemetry_payload_packer.sv
`timescale 1ns / 100ps

module tb_telemetry_payload_packer;
  import tpp_pkg::*;

  // Register index past the end of the map; writes to it must be dropped.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Cycles to let pass once the last byte is in, before new settings or the end.
  localparam int DRAIN_CYCLES = 40;

  // Timeout for the whole run, with a wide margin over the slowest correct run.
  localparam int TIMEOUT_NS = 3_000_000;

  localparam int PHASE_REPORTS = 40;

  logic      clk = 1'b0;
  logic      rst = 1'b1;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_DEVICE_ID;
  logic [15:0] cfg_data = '0;

  telemetry_payload_packer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Reports still to be offered, and payload bytes still owed by the block.
  in_item_t  pending_reports[$];
  out_item_t expected_bytes[$];

  // Local copy of the register file, tracked from the write port.
  logic [7:0]  cur_device_id = 8'h00;
  logic [7:0]  cur_firmware  = 8'h00;
  logic [15:0] cur_marker    = MARKER_RST;

  int        mismatches = 0;
  int        bytes_seen = 0;
  bit        calm = 1'b0;        // set for a phase with no idling on either side
  bit        report_taken = 1'b0;
  bit        byte_taken = 1'b0;
  int        send_gap = 0;
  int        hold_left = 0;
  out_item_t want;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // ---------------------------------------------------------------------------
  // Frame predictor: field saturation and layout, one frame per report
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] sat_signed16(input logic signed [31:0] v);
    if (v > 32'sd32767) return SAT_S16_HI;
    if (v < -32'sd32768) return SAT_S16_LO;
    return v[15:0];
  endfunction

  function automatic logic [15:0] clamp_count16(input logic [31:0] v);
    return (v > 32'd32767) ? SAT_COUNT : v[15:0];
  endfunction

  function automatic logic [15:0] clamp_unsigned16(input logic [31:0] v);
    return (v > 32'd65535) ? SAT_U16 : v[15:0];
  endfunction

  // Ten times the mean people count, rounded half up; marker when nothing scanned.
  function automatic logic [15:0] mean_people_x10(input logic [31:0] sum,
                                                  input logic [31:0] scans);
    longint unsigned s;
    longint unsigned n;
    longint unsigned q;
    s = sum;
    n = scans;
    if (n == 0) return cur_marker;
    q = (s * 10 + n / 2) / n;
    return (q > 32767) ? SAT_COUNT : q[15:0];
  endfunction

  // Build the frame for an accepted report and queue its bytes.
  task automatic predict_frame(input in_item_t r);
    logic [127:0] frame;   // byte k sits at bits 8k+7:8k, so 16-bit writes are little-endian
    logic         is_long;
    logic         is_counter;
    int           base;
    int           n_bytes;
    out_item_t    b;
    frame      = '0;
    is_long    = (r.command == CMD_SENSOR_LONG) || (r.command == CMD_COUNTER_LONG);
    is_counter = (r.command == CMD_COUNTER_LONG) || (r.command == CMD_COUNTER_SHORT);
    base       = is_long ? 3 : 0;
    n_bytes    = is_long ? LONG_EMIT : SHORT_EMIT;

    if (is_long) begin
      frame[7:0]   = HDR_TAG;
      frame[15:8]  = cur_device_id;
      frame[23:16] = cur_firmware;
    end
    if (is_counter) begin
      frame[8*base +: 16]       = (r.scan_total != 0) ? clamp_count16(r.peak_people)
                                                      : cur_marker;
      frame[8*(base + 2) +: 16] = mean_people_x10(r.people_sum, r.scan_total);
      frame[8*(base + 4) +: 16] = clamp_count16(r.motion_events);
      frame[8*(base + 6) +: 16] = clamp_count16(r.scan_total);
    end else begin
      frame[8*base +: 16]       = sat_signed16(r.channel_reading);
      frame[8*(base + 2) +: 16] = cur_marker;
      frame[8*(base + 4) +: 16] = cur_marker;
      frame[8*(base + 6) +: 16] = cur_marker;
    end
    if (is_long) begin
      frame[8*11 +: 16] = clamp_unsigned16(r.battery_millivolts);
      if (!is_counter) frame[8*15 +: 8] = r.range_code;
    end else begin
      frame[8*8 +: 16]  = sat_signed16(r.temperature_tenths);
      frame[8*10 +: 16] = clamp_unsigned16(r.battery_millivolts);
    end

    for (int k = 0; k < n_bytes; k++) begin
      b.payload_byte  = frame[8*k +: 8];
      b.byte_position = 4'(k);
      b.final_byte    = (k == n_bytes - 1);
      expected_bytes.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Mix of small values, saturation edges and full-range words.
  function automatic logic [31:0] pick_word();
    logic [31:0] edge_words [4] = '{32'h0000_0000, 32'hffff_ffff,
                                    32'h8000_0000, 32'h7fff_ffff};
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, 100);
      1: return 32'd32766 + $urandom_range(0, 2);
      2: return 32'd65534 + $urandom_range(0, 2);
      3: return edge_words[$urandom_range(0, 3)];
      4: return ~32'($urandom_range(0, 40000));      // small negative
      5: return 32'hffff_8000 - $urandom_range(0, 2); // int16 low edge
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_report();
    in_item_t r;
    r.command            = 2'($urandom_range(0, 3));
    r.channel_reading    = pick_word();
    r.battery_millivolts = pick_word();
    r.range_code         = 8'($urandom);
    r.temperature_tenths = pick_word();
    r.peak_people        = pick_word();
    r.motion_events      = pick_word();
    case ($urandom_range(0, 3))
      0: r.scan_total = '0;
      1: r.scan_total = $urandom_range(1, 20);
      2: r.scan_total = $urandom_range(1, 5000);
      default: r.scan_total = pick_word();
    endcase
    // Keep most averages in range so the divider result is exercised, not just clamped.
    if ($urandom_range(0, 2) != 0)
      r.people_sum = 32'(r.scan_total * $urandom_range(0, 60) + $urandom_range(0, 9));
    else
      r.people_sum = pick_word();
    return r;
  endfunction

  task automatic push_sensor(input logic [1:0] cmd, input logic [31:0] chan,
                             input logic [31:0] temp, input logic [31:0] batt,
                             input logic [7:0] rng);
    in_item_t r;
    r = random_report();   // counter fields stay random: the format ignores them
    r.command            = cmd;
    r.channel_reading    = chan;
    r.temperature_tenths = temp;
    r.battery_millivolts = batt;
    r.range_code         = rng;
    pending_reports.push_back(r);
  endtask

  task automatic push_counter(input logic [1:0] cmd, input logic [31:0] peak,
                              input logic [31:0] sum, input logic [31:0] scans,
                              input logic [31:0] motion, input logic [31:0] temp,
                              input logic [31:0] batt);
    in_item_t r;
    r = random_report();
    r.command            = cmd;
    r.peak_people        = peak;
    r.people_sum         = sum;
    r.scan_total         = scans;
    r.motion_events      = motion;
    r.temperature_tenths = temp;
    r.battery_millivolts = batt;
    pending_reports.push_back(r);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold until every report is in and every byte is out, then let the block settle.
  task automatic wait_idle();
    bit idle;
    idle = 1'b0;
    while (!idle) begin
      @(posedge clk);
      #1;
      idle = (pending_reports.size() == 0) && !in_valid && (expected_bytes.size() == 0);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer queued reports at the falling edge, hold each until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !report_taken) begin
      // hold: valid and payload stay put until the handshake
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (pending_reports.size() > 0) begin
      in_item  <= pending_reports.pop_front();
      in_valid <= 1'b1;
      send_gap = draw_wait();   // idle cycles after this report is taken
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: after each byte, stall ready for a drawn number of cycles
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (byte_taken) hold_left = draw_wait();
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: track register writes, predict on report handshakes, check bytes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    report_taken = 1'b0;
    byte_taken   = 1'b0;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DEVICE_ID:        cur_device_id = cfg_data[7:0];
          REG_FIRMWARE_VERSION: cur_firmware  = cfg_data[7:0];
          REG_MISSING_MARKER:   cur_marker    = cfg_data;
          default: ;            // drop writes past the register map
        endcase
      end
      if (in_valid && in_ready) begin
        report_taken = 1'b1;
        predict_frame(in_item);
      end
      if (out_valid && out_ready) begin
        byte_taken = 1'b1;
        if (expected_bytes.size() == 0) begin
          flag_mismatch($sformatf("byte %0d: unexpected data %02h pos %0d last %0b",
                                  bytes_seen, out_item.payload_byte,
                                  out_item.byte_position, out_item.final_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_item !== want)
            flag_mismatch($sformatf(
              "byte %0d: got data %02h pos %0d last %0b, want data %02h pos %0d last %0b",
              bytes_seen, out_item.payload_byte, out_item.byte_position,
              out_item.final_byte, want.payload_byte, want.byte_position,
              want.final_byte));
        end
        bytes_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed reports at reset settings, then random phases
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]  id;
    logic [7:0]  fw;
    logic [15:0] marker;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Sensor frames: int16 saturation both ways, battery clamp, range byte.
    push_sensor(CMD_SENSOR_LONG, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 8'hff);
    push_sensor(CMD_SENSOR_LONG, 32'h8000_0000, 32'h0, 32'h0, 8'h00);
    push_sensor(CMD_SENSOR_LONG, 32'd32767, 32'h0, 32'd65535, 8'h5a);
    push_sensor(CMD_SENSOR_LONG, 32'hffff_8000, 32'h0, 32'd65536, 8'ha5);
    push_sensor(CMD_SENSOR_LONG, 32'd32768, 32'h0, 32'd1, 8'h01);
    push_sensor(CMD_SENSOR_SHORT, 32'hffff_ffff, 32'h7fff_ffff, 32'd123, 8'h3c);
    push_sensor(CMD_SENSOR_SHORT, 32'hffff_7fff, 32'h8000_0000, 32'hffff_ffff, 8'hc3);
    push_sensor(CMD_SENSOR_SHORT, 32'h0, 32'hffff_8000, 32'd65535, 8'h00);

    // Counter frames: zero scans, count clamps, average rounding and clamp.
    push_counter(CMD_COUNTER_LONG, 32'd5, 32'd7, 32'd0, 32'd9, 32'h0, 32'd3300);
    push_counter(CMD_COUNTER_LONG, 32'hffff_ffff, 32'hffff_ffff, 32'd1, 32'hffff_ffff,
                 32'h0, 32'hffff_ffff);
    push_counter(CMD_COUNTER_LONG, 32'd32767, 32'hffff_ffff, 32'hffff_ffff, 32'd32768,
                 32'h0, 32'd0);
    push_counter(CMD_COUNTER_LONG, 32'd32768, 32'd1, 32'd4, 32'd0, 32'h0, 32'd65536);
    push_counter(CMD_COUNTER_LONG, 32'd0, 32'd1, 32'd3, 32'd32767, 32'h0, 32'd4000);
    push_counter(CMD_COUNTER_LONG, 32'd100, 32'd3277, 32'd1, 32'd1, 32'h0, 32'd2900);
    push_counter(CMD_COUNTER_LONG, 32'd7, 32'd32767, 32'd10, 32'd2, 32'h0, 32'd3100);
    push_counter(CMD_COUNTER_SHORT, 32'd10, 32'd0, 32'd0, 32'd0, 32'h7fff_ffff, 32'd0);
    push_counter(CMD_COUNTER_SHORT, 32'd2, 32'd5, 32'd2, 32'd3, 32'h8000_0000, 32'd70000);
    push_counter(CMD_COUNTER_SHORT, 32'd0, 32'd0, 32'd32768, 32'd1, 32'hffff_fffb,
                 32'd65535);
    push_counter(CMD_COUNTER_SHORT, 32'd1, 32'd1, 32'd1, 32'd1, 32'd100, 32'd3000);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin id = 8'hff; fw = 8'hff; marker = 16'h7fff; end
        1: begin id = 8'h00; fw = 8'h00; marker = 16'h0000; end
        3: begin id = 8'h00; fw = 8'hff; marker = 16'hffff; end
        4: begin id = 8'hff; fw = 8'h00; marker = 16'h8000; end
        default: begin id = 8'($urandom); fw = 8'($urandom); marker = 16'($urandom); end
      endcase
      // Upper data bits are junk for the byte-wide registers; they must be dropped.
      write_reg(REG_DEVICE_ID, {8'($urandom), id});
      write_reg(REG_FIRMWARE_VERSION, {8'($urandom), fw});
      write_reg(REG_MISSING_MARKER, marker);
      write_reg(REG_UNUSED, 16'($urandom));
      calm = (p == 3);
      for (int i = 0; i < PHASE_REPORTS; i++)
        pending_reports.push_back(random_report());
      // The sender runs dry here and waits for the whole phase to drain.
      wait_idle();
    end

    if (mismatches == 0 && expected_bytes.size() == 0)
      $display("telemetry_payload_packer test passed");
    else
      $display("telemetry_payload_packer test failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("telemetry_payload_packer test failed");
    $finish;
  end

endmodule
